>>> hdl/dual_pol_power_integrator_core_macros.svh
// assertion macros used by the checker file
`ifndef DUAL_POL_POWER_INTEGRATOR_CORE_MACROS_SVH
`define DUAL_POL_POWER_INTEGRATOR_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define DPPI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define DPPI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, also checked during reset
`define DPPI_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/dppi_pkg.sv
// shared constants, types and a helper function of the power integrator
package dppi_pkg;

  localparam int MAX_FREQ_DEF = 1024;
  localparam int ACC_W        = 23;
  localparam int PWR_W        = 8;
  localparam int BYTE_W       = 8;
  localparam int NF_W         = 11;
  localparam int FPI_W        = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int MID_DEPTH    = 4;
  localparam int OUT_DEPTH    = 4;

  localparam logic [NF_W-1:0]  NF_RESET  = NF_W'(1024);
  localparam logic [FPI_W-1:0] FPI_RESET = FPI_W'(8192);

  typedef enum logic [0:0] {
    CFG_CHAN_COUNT = 1'b0,
    CFG_FRAMES     = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic first;
    logic last_frame;
    logic last_chan;
  } item_ctrl_t;

  function automatic logic [PWR_W-1:0] nibble_power(input logic [BYTE_W-1:0] b);
    logic signed [4:0] re;
    logic signed [4:0] im;
    logic signed [9:0] re_sq;
    logic signed [9:0] im_sq;
    logic signed [9:0] sum;
    re    = $signed({1'b0, b[7:4]}) - 5'sd8;
    im    = $signed({1'b0, b[3:0]}) - 5'sd8;
    re_sq = re * re;
    im_sq = im * im;
    sum   = re_sq + im_sq;
    return sum[PWR_W-1:0];
  endfunction

endpackage

>>> hdl/dppi_fifo.sv
// small register queue used between the front and back and on the result side
module dppi_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic [CNT_W-1:0] count
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

>>> hdl/dppi_front.sv
// front end: config registers, channel and frame counters, sample power
module dppi_front #(
  parameter int MAX_FREQ = dppi_pkg::MAX_FREQ_DEF,
  localparam int CH_W = (MAX_FREQ > 1) ? $clog2(MAX_FREQ) : 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  dppi_pkg::cfg_idx_t                  cfg_index,
  input  logic [dppi_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                cfg_ready,
  input  logic                                push,
  input  logic [dppi_pkg::BYTE_W-1:0]         x_byte,
  input  logic [dppi_pkg::BYTE_W-1:0]         y_byte,
  input  logic                                q_full,
  output logic                                q_push,
  output logic [CH_W-1:0]                     q_ch,
  output logic [dppi_pkg::PWR_W-1:0]          q_px,
  output logic [dppi_pkg::PWR_W-1:0]          q_py,
  output dppi_pkg::item_ctrl_t                q_ctrl
);

  localparam int NF_W  = dppi_pkg::NF_W;
  localparam int FPI_W = dppi_pkg::FPI_W;
  localparam int CMP_W = ((NF_W > CH_W + 1) ? NF_W : CH_W + 1) + 1;

  logic [NF_W-1:0]  chan_total;
  logic [FPI_W-1:0] frames_per_integration;
  logic [CH_W-1:0]  chan;
  logic [FPI_W-1:0] frame;

  logic [CMP_W-1:0] nf_eff;
  logic [CMP_W-1:0] ch_plus;
  logic [FPI_W-1:0] fpi_eff;
  logic [FPI_W:0]   frame_plus;
  logic             last_chan;
  logic             last_frame;
  logic             accept;

  assign cfg_ready = 1'b1;
  assign accept    = push && !q_full;

  always_comb begin
    if (chan_total == '0) begin
      nf_eff = CMP_W'(1);
    end else if (CMP_W'(chan_total) > CMP_W'(MAX_FREQ)) begin
      nf_eff = CMP_W'(MAX_FREQ);
    end else begin
      nf_eff = CMP_W'(chan_total);
    end
    fpi_eff    = (frames_per_integration == '0) ? FPI_W'(1) : frames_per_integration;
    ch_plus    = CMP_W'(chan) + CMP_W'(1);
    frame_plus = {1'b0, frame} + (FPI_W + 1)'(1);
    last_chan  = (ch_plus >= nf_eff);
    last_frame = (frame_plus >= {1'b0, fpi_eff});
  end

  assign q_push            = accept;
  assign q_ch              = chan;
  assign q_px              = dppi_pkg::nibble_power(x_byte);
  assign q_py              = dppi_pkg::nibble_power(y_byte);
  assign q_ctrl.first      = (frame == '0);
  assign q_ctrl.last_frame = last_frame;
  assign q_ctrl.last_chan  = last_chan;

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_total             <= dppi_pkg::NF_RESET;
      frames_per_integration <= dppi_pkg::FPI_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dppi_pkg::CFG_CHAN_COUNT: chan_total             <= cfg_data[NF_W-1:0];
        dppi_pkg::CFG_FRAMES:     frames_per_integration <= cfg_data[FPI_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan  <= '0;
      frame <= '0;
    end else if (accept) begin
      if (last_chan) begin
        chan  <= '0;
        frame <= last_frame ? '0 : frame_plus[FPI_W-1:0];
      end else begin
        chan <= chan + 1'b1;
      end
    end
  end

endmodule

>>> hdl/dppi_back.sv
// back end: accumulator memory read-modify-write with bypass, result push
module dppi_back #(
  parameter int MAX_FREQ = dppi_pkg::MAX_FREQ_DEF,
  localparam int CH_W   = (MAX_FREQ > 1) ? $clog2(MAX_FREQ) : 1,
  localparam int OCNT_W = $clog2(dppi_pkg::OUT_DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  input  logic [CH_W-1:0]                q_ch,
  input  logic [dppi_pkg::PWR_W-1:0]     q_px,
  input  logic [dppi_pkg::PWR_W-1:0]     q_py,
  input  dppi_pkg::item_ctrl_t           q_ctrl,
  output logic                           q_pop,
  input  logic [OCNT_W-1:0]              out_count,
  output logic                           o_push,
  output logic [CH_W-1:0]                o_ch,
  output logic [dppi_pkg::ACC_W-1:0]     o_x,
  output logic [dppi_pkg::ACC_W-1:0]     o_y,
  output logic                           o_last
);

  localparam int ACC_W = dppi_pkg::ACC_W;
  localparam int PWR_W = dppi_pkg::PWR_W;

  logic [2*ACC_W-1:0] mem [MAX_FREQ];
  logic [2*ACC_W-1:0] mem_q;

  logic                 b_valid;
  logic [CH_W-1:0]      b_ch;
  logic [PWR_W-1:0]     b_px;
  logic [PWR_W-1:0]     b_py;
  dppi_pkg::item_ctrl_t b_ctrl;
  logic                 byp;
  logic [ACC_W-1:0]     byp_x;
  logic [ACC_W-1:0]     byp_y;

  logic [ACC_W-1:0]     old_x;
  logic [ACC_W-1:0]     old_y;
  logic [ACC_W-1:0]     sum_x;
  logic [ACC_W-1:0]     sum_y;
  logic                 b_res;
  logic [OCNT_W:0]      pending;

  // reserve a result slot for the item in flight
  assign b_res   = b_valid && b_ctrl.last_frame;
  assign pending = (OCNT_W + 1)'(out_count) + (OCNT_W + 1)'(b_res);
  assign q_pop   = !q_empty && (pending < (OCNT_W + 1)'(dppi_pkg::OUT_DEPTH));

  always_comb begin
    old_x = byp ? byp_x : mem_q[2*ACC_W-1:ACC_W];
    old_y = byp ? byp_y : mem_q[ACC_W-1:0];
    sum_x = b_ctrl.first ? ACC_W'(b_px) : old_x + ACC_W'(b_px);
    sum_y = b_ctrl.first ? ACC_W'(b_py) : old_y + ACC_W'(b_py);
  end

  assign o_push = b_res;
  assign o_ch   = b_ch;
  assign o_x    = sum_x;
  assign o_y    = sum_y;
  assign o_last = b_ctrl.last_chan;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mem_q  <= mem[q_ch];
      b_ch   <= q_ch;
      b_px   <= q_px;
      b_py   <= q_py;
      b_ctrl <= q_ctrl;
      byp    <= b_valid && (b_ch == q_ch);
      byp_x  <= sum_x;
      byp_y  <= sum_y;
    end
    if (b_valid) begin
      mem[b_ch] <= {sum_x, sum_y};
    end
  end

endmodule

>>> hdl/dual_pol_power_integrator_core.sv
// Dual-polarization power integrator. Takes one channel sample per clock, sustained, as long
// as results are drained; the accumulator memory (one read and one write port) does a
// read-modify-write per item, read at the queue pop and written from the back-end stage,
// with a bypass for back-to-back hits on one channel. Results come only on the last frame
// of an integration. The accumulator memory needs no clearing pass after reset: the first
// frame of each integration loads it.
module dual_pol_power_integrator_core #(
  parameter int MAX_FREQ = dppi_pkg::MAX_FREQ_DEF,
  localparam int CH_W = (MAX_FREQ > 1) ? $clog2(MAX_FREQ) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  dppi_pkg::cfg_idx_t              cfg_index,
  input  logic [dppi_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            push,
  output logic                            full,
  input  logic [dppi_pkg::BYTE_W-1:0]     x_byte,
  input  logic [dppi_pkg::BYTE_W-1:0]     y_byte,
  input  logic                            pop,
  output logic                            empty,
  output logic [CH_W-1:0]                 freq_index,
  output logic [dppi_pkg::ACC_W-1:0]      x_power,
  output logic [dppi_pkg::ACC_W-1:0]      y_power,
  output logic                            last_of_integration
);

  localparam int PWR_W  = dppi_pkg::PWR_W;
  localparam int ACC_W  = dppi_pkg::ACC_W;
  localparam int CTL_W  = $bits(dppi_pkg::item_ctrl_t);
  localparam int MID_W  = CH_W + 2 * PWR_W + CTL_W;
  localparam int OUT_W  = CH_W + 2 * ACC_W + 1;
  localparam int MCNT_W = $clog2(dppi_pkg::MID_DEPTH + 1);
  localparam int OCNT_W = $clog2(dppi_pkg::OUT_DEPTH + 1);

  logic                 f_push;
  logic [CH_W-1:0]      f_ch;
  logic [PWR_W-1:0]     f_px;
  logic [PWR_W-1:0]     f_py;
  dppi_pkg::item_ctrl_t f_ctrl;

  logic [MID_W-1:0]     mid_rdata;
  logic                 mid_empty;
  logic                 mid_pop;
  logic [MCNT_W-1:0]    mid_count;

  logic [CH_W-1:0]      m_ch;
  logic [PWR_W-1:0]     m_px;
  logic [PWR_W-1:0]     m_py;
  dppi_pkg::item_ctrl_t m_ctrl;

  logic                 o_push;
  logic [CH_W-1:0]      o_ch;
  logic [ACC_W-1:0]     o_x;
  logic [ACC_W-1:0]     o_y;
  logic                 o_last;
  logic [OUT_W-1:0]     out_rdata;
  logic                 out_full;
  logic [OCNT_W-1:0]    out_count;

  dppi_front #(.MAX_FREQ(MAX_FREQ)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .push      (push),
    .x_byte    (x_byte),
    .y_byte    (y_byte),
    .q_full    (full),
    .q_push    (f_push),
    .q_ch      (f_ch),
    .q_px      (f_px),
    .q_py      (f_py),
    .q_ctrl    (f_ctrl)
  );

  dppi_fifo #(.WIDTH(MID_W), .DEPTH(dppi_pkg::MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata ({f_ch, f_px, f_py, f_ctrl}),
    .full  (full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .count (mid_count)
  );

  assign {m_ch, m_px, m_py, m_ctrl} = mid_rdata;

  dppi_back #(.MAX_FREQ(MAX_FREQ)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (mid_empty || (mid_count == '0)),
    .q_ch      (m_ch),
    .q_px      (m_px),
    .q_py      (m_py),
    .q_ctrl    (m_ctrl),
    .q_pop     (mid_pop),
    .out_count (out_count),
    .o_push    (o_push),
    .o_ch      (o_ch),
    .o_x       (o_x),
    .o_y       (o_y),
    .o_last    (o_last)
  );

  dppi_fifo #(.WIDTH(OUT_W), .DEPTH(dppi_pkg::OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (o_push),
    .wdata ({o_ch, o_x, o_y, o_last}),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty),
    .count (out_count)
  );

  assign {freq_index, x_power, y_power, last_of_integration} = out_rdata;

  // slot reservation in the back end keeps the result queue from overflowing
  logic unused_out_full;
  assign unused_out_full = out_full;

endmodule

>>> hdl/dppi_checker.sv
// port-level checks of the power integrator, bound to the top level
`include "dual_pol_power_integrator_core_macros.svh"

module dppi_checker #(
  parameter int MAX_FREQ = dppi_pkg::MAX_FREQ_DEF,
  localparam int CH_W = (MAX_FREQ > 1) ? $clog2(MAX_FREQ) : 1
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       push,
  input logic                       full,
  input logic                       pop,
  input logic                       empty,
  input logic [CH_W-1:0]            freq_index,
  input logic [dppi_pkg::ACC_W-1:0] x_power,
  input logic [dppi_pkg::ACC_W-1:0] y_power,
  input logic                       last_of_integration
);

  `DPPI_ASSERT_ALWAYS(a_reset_state, rst, empty && !full, "queues not clear after reset")

  `DPPI_ASSERT_NOW(a_full_needs_push, !$past(rst) && $rose(full), $past(push), "full rose without an accepted item")

  `DPPI_ASSERT_NOW(a_empty_needs_pop, !$past(rst) && $rose(empty), $past(pop), "empty rose without a taken result")

  `DPPI_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(freq_index) && $stable(x_power) && $stable(y_power) && $stable(last_of_integration), "waiting result changed")

endmodule

bind dual_pol_power_integrator_core dppi_checker #(.MAX_FREQ(MAX_FREQ)) u_dppi_checker (
  .clk                 (clk),
  .rst                 (rst),
  .push                (push),
  .full                (full),
  .pop                 (pop),
  .empty               (empty),
  .freq_index          (freq_index),
  .x_power             (x_power),
  .y_power             (y_power),
  .last_of_integration (last_of_integration)
);

>>> sim/tb_dual_pol_power_integrator_core.sv
// self-checking testbench of the dual-polarization power integrator core
module tb_dual_pol_power_integrator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BYTE_W       = dppi_pkg::BYTE_W;
  localparam int CFG_DATA_W   = dppi_pkg::CFG_DATA_W;
  localparam int ACC_W        = dppi_pkg::ACC_W;
  localparam int NF_W         = dppi_pkg::NF_W;
  localparam int FPI_W        = dppi_pkg::FPI_W;
  localparam int MAX_FREQ_DEF = dppi_pkg::MAX_FREQ_DEF;

  localparam int RANDOM_SAMPLES = 800;
  localparam int SETTLE_CYCLES  = 8;
  localparam int CYCLE_LIMIT    = 400000;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_WRITE,
    OP_DRAIN,
    OP_MODE
  } op_kind_t;

  typedef struct packed {
    op_kind_t              kind;
    logic [BYTE_W-1:0]     x;
    logic [BYTE_W-1:0]     y;
    dppi_pkg::cfg_idx_t    idx;
    logic [CFG_DATA_W-1:0] data;
    logic [6:0]            idle;
    logic [6:0]            stall;
  } bench_op_t;

  typedef struct packed {
    logic [9:0]       freq_index;
    logic [ACC_W-1:0] x_power;
    logic [ACC_W-1:0] y_power;
    logic             last;
  } power_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  dppi_pkg::cfg_idx_t    cfg_index = dppi_pkg::CFG_CHAN_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  push = 1'b0;
  logic                  full;
  logic [BYTE_W-1:0]     x_byte = '0;
  logic [BYTE_W-1:0]     y_byte = '0;
  logic                  pop = 1'b0;
  logic                  empty;
  logic [9:0]            freq_index;
  logic [ACC_W-1:0]      x_power;
  logic [ACC_W-1:0]      y_power;
  logic                  last_of_integration;

  dual_pol_power_integrator_core uut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .push                (push),
    .full                (full),
    .x_byte              (x_byte),
    .y_byte              (y_byte),
    .pop                 (pop),
    .empty               (empty),
    .freq_index          (freq_index),
    .x_power             (x_power),
    .y_power             (y_power),
    .last_of_integration (last_of_integration)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bench_op_t     pending_ops [$];
  power_result_t power_due [$];
  bench_op_t     cur_op;
  logic          op_live = 1'b0;
  logic          push_taken = 1'b0;
  logic          cfg_taken = 1'b0;
  int            quiet = 0;
  int            send_idle = 0;
  int            recv_stall = 0;
  int            mismatches = 0;
  int            cycle_count = 0;

  // predictor state
  logic [NF_W-1:0]  nf_reg = dppi_pkg::NF_RESET;
  logic [FPI_W-1:0] fpi_reg = dppi_pkg::FPI_RESET;
  logic [ACC_W-1:0] x_acc [MAX_FREQ_DEF];
  logic [ACC_W-1:0] y_acc [MAX_FREQ_DEF];
  logic [9:0]       chan_cnt = '0;
  logic [15:0]      frame_cnt = '0;

  // stimulus planning state
  logic [NF_W-1:0]  plan_nf = dppi_pkg::NF_RESET;
  logic [FPI_W-1:0] plan_fpi = dppi_pkg::FPI_RESET;
  int               plan_ch = 0;
  int               plan_fr = 0;
  int               sample_total = 0;

  function automatic int active_channels(input logic [NF_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_FREQ_DEF) return MAX_FREQ_DEF;
    return int'(raw);
  endfunction

  function automatic int active_frames(input logic [FPI_W-1:0] raw);
    if (raw == 0) return 1;
    return int'(raw);
  endfunction

  function automatic int sample_power(input logic [BYTE_W-1:0] b);
    int re;
    int im;
    re = int'(b[7:4]) - 8;
    im = int'(b[3:0]) - 8;
    return re * re + im * im;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    if ($urandom_range(0, 99) >= 15) return BYTE_W'($urandom_range(0, 255));
    case ($urandom_range(0, 6))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h88;
      3: return 8'h0f;
      4: return 8'hf0;
      5: return 8'h80;
      default: return 8'h08;
    endcase
  endfunction

  task automatic integrate_sample(input logic [BYTE_W-1:0] xb, input logic [BYTE_W-1:0] yb);
    int            nf;
    int            nfr;
    int            ch;
    logic          lc;
    logic          lf;
    power_result_t r;
    nf  = active_channels(nf_reg);
    nfr = active_frames(fpi_reg);
    ch  = int'(chan_cnt);
    if (frame_cnt == 0) begin
      x_acc[ch] = ACC_W'(sample_power(xb));
      y_acc[ch] = ACC_W'(sample_power(yb));
    end else begin
      x_acc[ch] = x_acc[ch] + ACC_W'(sample_power(xb));
      y_acc[ch] = y_acc[ch] + ACC_W'(sample_power(yb));
    end
    lc = (int'(chan_cnt) + 1) >= nf;
    lf = (int'(frame_cnt) + 1) >= nfr;
    if (lf) begin
      r.freq_index = chan_cnt;
      r.x_power    = x_acc[ch];
      r.y_power    = y_acc[ch];
      r.last       = lc;
      power_due.push_back(r);
    end
    if (lc) begin
      chan_cnt  = '0;
      frame_cnt = lf ? 16'd0 : frame_cnt + 16'd1;
    end else begin
      chan_cnt = chan_cnt + 10'd1;
    end
  endtask

  task automatic plan_sample(input logic [BYTE_W-1:0] xb, input logic [BYTE_W-1:0] yb);
    bench_op_t op;
    op      = '0;
    op.kind = OP_SAMPLE;
    op.x    = xb;
    op.y    = yb;
    pending_ops.push_back(op);
    sample_total++;
    if (plan_ch + 1 >= active_channels(plan_nf)) begin
      plan_ch = 0;
      plan_fr = (plan_fr + 1 >= active_frames(plan_fpi)) ? 0 : plan_fr + 1;
    end else begin
      plan_ch++;
    end
  endtask

  task automatic plan_write(input dppi_pkg::cfg_idx_t idx,
                            input logic [CFG_DATA_W-1:0] data);
    bench_op_t op;
    op      = '0;
    op.kind = OP_WRITE;
    op.idx  = idx;
    op.data = data;
    pending_ops.push_back(op);
    if (idx == dppi_pkg::CFG_CHAN_COUNT) plan_nf = data[NF_W-1:0];
    else plan_fpi = data[FPI_W-1:0];
  endtask

  task automatic plan_op(input op_kind_t kind, input int idle, input int stall);
    bench_op_t op;
    op       = '0;
    op.kind  = kind;
    op.idle  = 7'(idle);
    op.stall = 7'(stall);
    pending_ops.push_back(op);
  endtask

  // driver
  always @(negedge clk) begin : drive
    logic next_push;
    logic next_cv;
    logic settled;
    next_push = push;
    next_cv   = cfg_valid;
    settled   = (power_due.size() == 0) && (quiet >= SETTLE_CYCLES);
    if (!rst) begin
      if (push_taken || cfg_taken) begin
        next_push = 1'b0;
        next_cv   = 1'b0;
        op_live   = 1'b0;
      end
      if (!op_live && pending_ops.size() != 0) begin
        cur_op  = pending_ops.pop_front();
        op_live = 1'b1;
      end
      if (op_live) begin
        case (cur_op.kind)
          OP_MODE: begin
            send_idle  = int'(cur_op.idle);
            recv_stall = int'(cur_op.stall);
            op_live    = 1'b0;
          end
          OP_DRAIN: begin
            if (settled) op_live = 1'b0;
          end
          OP_WRITE: begin
            if (!next_cv && settled) begin
              next_cv   = 1'b1;
              cfg_index <= cur_op.idx;
              cfg_data  <= cur_op.data;
            end
          end
          default: begin
            if (!next_push && $urandom_range(99) >= send_idle) begin
              next_push = 1'b1;
              x_byte    <= cur_op.x;
              y_byte    <= cur_op.y;
            end
          end
        endcase
      end
    end
    push      <= next_push;
    cfg_valid <= next_cv;
  end

  always @(negedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= recv_stall);
  end

  // monitor
  always @(posedge clk) begin : watch
    power_result_t want;
    if (rst) begin
      push_taken = 1'b0;
      cfg_taken  = 1'b0;
      quiet      = 0;
    end else begin
      if (pop && !empty) begin
        if (power_due.size() == 0) begin
          $error("unexpected result for freq_index %0d", freq_index);
          mismatches++;
        end else begin
          want = power_due.pop_front();
          if (freq_index !== want.freq_index) begin
            $error("freq_index expected %0d got %0d", want.freq_index, freq_index);
            mismatches++;
          end
          if (x_power !== want.x_power) begin
            $error("x_power expected %0d got %0d", want.x_power, x_power);
            mismatches++;
          end
          if (y_power !== want.y_power) begin
            $error("y_power expected %0d got %0d", want.y_power, y_power);
            mismatches++;
          end
          if (last_of_integration !== want.last) begin
            $error("last_of_integration expected %0d got %0d", want.last, last_of_integration);
            mismatches++;
          end
        end
      end
      push_taken = push && !full;
      cfg_taken  = cfg_valid && cfg_ready;
      if (cfg_taken) begin
        if (cfg_index == dppi_pkg::CFG_CHAN_COUNT) nf_reg = cfg_data[NF_W-1:0];
        else fpi_reg = cfg_data[FPI_W-1:0];
      end
      if (push_taken) integrate_sample(x_byte, y_byte);
      if (push_taken || power_due.size() != 0) quiet = 0;
      else if (quiet < 1000) quiet++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[dual_pol_power_integrator_core] ERROR");
      $finish;
    end
  end

  initial begin
    int k;
    int phase;
    int cur_phase;
    int base;
    int r;
    logic [CFG_DATA_W-1:0] word;

    // reset defaults, then shrink the channel count mid-frame
    plan_sample(8'h00, 8'hff);
    plan_sample(8'hff, 8'h00);
    plan_sample(8'h88, 8'h88);
    plan_sample(8'h0f, 8'hf0);
    plan_sample(8'hf0, 8'h0f);
    plan_write(dppi_pkg::CFG_CHAN_COUNT, 16'd3);
    plan_sample(8'h80, 8'h08);
    // frame count now beyond the new bound
    plan_write(dppi_pkg::CFG_FRAMES, 16'd1);
    plan_sample(8'h00, 8'h00);
    plan_sample(8'hff, 8'hff);
    plan_sample(8'h7f, 8'h18);
    // saturated channel count and widest frame count
    plan_write(dppi_pkg::CFG_CHAN_COUNT, 16'hffff);
    plan_write(dppi_pkg::CFG_FRAMES, 16'hffff);
    repeat (2) plan_sample(8'h00, 8'h00);
    plan_write(dppi_pkg::CFG_CHAN_COUNT, 16'd4);
    repeat (10) plan_sample(pick_byte(), pick_byte());
    plan_write(dppi_pkg::CFG_FRAMES, 16'd2);
    repeat (4) plan_sample(pick_byte(), pick_byte());
    // zero registers act as one
    plan_write(dppi_pkg::CFG_CHAN_COUNT, 16'hf800);
    plan_write(dppi_pkg::CFG_FRAMES, 16'd0);
    plan_sample(8'h00, 8'hff);
    plan_sample(8'h55, 8'haa);

    // one full-width frame
    plan_write(dppi_pkg::CFG_CHAN_COUNT, 16'd1024);
    plan_write(dppi_pkg::CFG_FRAMES, 16'd1);
    repeat (1024) plan_sample(pick_byte(), pick_byte());

    base      = sample_total;
    cur_phase = 0;
    while (sample_total - base < RANDOM_SAMPLES) begin
      phase = (sample_total - base) * 4 / RANDOM_SAMPLES;
      if (phase != cur_phase) begin
        cur_phase = phase;
        case (phase)
          1: plan_op(OP_MODE, 61, 0);
          2: plan_op(OP_MODE, 0, 61);
          default: plan_op(OP_MODE, 37, 37);
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 60) k = $urandom_range(1, 6);
      else if (r < 90) k = $urandom_range(7, 40);
      else k = 0;
      word = {5'($urandom_range(0, 31)), 11'(k)};
      plan_write(dppi_pkg::CFG_CHAN_COUNT, word);
      r = $urandom_range(0, 99);
      if (r < 70) k = $urandom_range(1, 3);
      else if (r < 90) k = $urandom_range(4, 10);
      else k = 0;
      plan_write(dppi_pkg::CFG_FRAMES, 16'(k));
      k = active_channels(plan_nf) * active_frames(plan_fpi) * $urandom_range(1, 2);
      if (k > 2 && $urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, k - 1)) plan_sample(pick_byte(), pick_byte());
        if ($urandom_range(0, 1) == 1)
          plan_write(dppi_pkg::CFG_CHAN_COUNT,
                     16'($urandom_range(1, active_channels(plan_nf))));
        else
          plan_write(dppi_pkg::CFG_FRAMES, 16'($urandom_range(1, 10)));
        while (plan_ch != 0 || plan_fr != 0) plan_sample(pick_byte(), pick_byte());
      end else begin
        repeat (k) plan_sample(pick_byte(), pick_byte());
      end
      if ($urandom_range(0, 7) == 0) plan_op(OP_DRAIN, 0, 0);
    end

    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    while (pending_ops.size() != 0 || op_live) @(posedge clk);
    while (power_due.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[dual_pol_power_integrator_core] OK");
    end else begin
      $display("[dual_pol_power_integrator_core] ERROR");
    end
    $finish;
  end

endmodule
